@@ rtl/nrsh_pkg.sv @@
`default_nettype none
package nrsh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH       = 18;
    localparam int PARAM_WIDTH     = 31;
    localparam int PARAM_SHIFT     = 16;
    // saturation test: n1 >= d << (PARAM_WIDTH - PARAM_SHIFT)
    localparam int SAT_SHIFT       = PARAM_WIDTH - PARAM_SHIFT;
    localparam int T1_SHIFT        = PARAM_WIDTH - 1;

    localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = '1;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } nrsh_op_t;

    typedef struct packed {
        logic     start;
        nrsh_op_t op;
        logic     clr;
        logic     neg;
    } nrsh_cmd_t;

endpackage
`default_nettype wire

@@ rtl/nearest_ray_segment_hit_top.sv @@
`default_nettype none
// Nearest hit of a 2D ray on a run of wall segments, Q16.16 fixed point. Each request
// carries one ray and one segment; the nearest hit with ray parameter T1 >= 0 and
// segment parameter 0 <= T2 <= 1 is kept, and the request marked with s_tlast returns
// one result (hit flag, point, saturated T1) and clears the kept hit. Parallel or
// degenerate segments never hit. One shift-add/subtract unit computes the six cross
// products, the T1 quotient and the two point offsets one bit per cycle, so a miss is
// the quickest request and a hit that becomes the new nearest the slowest. s_tready is
// high only between requests; a waiting result sits in its own register and does not
// hold off the next request.
module nearest_ray_segment_hit_top
    import nrsh_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_BITS     = 6 * COORD_WIDTH + 2 * DIR_WIDTH,
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = 2 * COORD_WIDTH + PARAM_WIDTH,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  wire logic [IN_W-1:0]     s_tdata,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // hit_x, hit_y, hit_param
    output logic [OUT_W-1:0]         m_tdata,
    // hit_found
    output logic                     m_tuser
);

    localparam int CW       = COORD_WIDTH;
    localparam int SW       = CW + 1;
    localparam int DW       = CW + 20;
    localparam int N1W      = 2 * CW + 3;
    localparam int WW       = (2 * CW + 22 > CW + 52) ? 2 * CW + 22 : CW + 52;
    localparam int MBW      = CW + 2;
    localparam int QW       = (CW + 1 > PARAM_WIDTH) ? CW + 1 : PARAM_WIDTH;
    localparam int MAXN     = (MBW > QW) ? MBW : QW;
    localparam int NBW      = $clog2(MAXN + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_D0,
        S_D1,
        S_N1A,
        S_N1B,
        S_N2A,
        S_N2B,
        S_TEST,
        S_SAT,
        S_T1,
        S_CMP,
        S_XM,
        S_XD,
        S_YM,
        S_YD,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic                    pend_reg;
    logic [SW-1:0]           sdx_reg, sdy_reg, qx_reg, qy_reg;
    logic [DIR_WIDTH-1:0]    rx_reg, ry_reg;
    logic [CW-1:0]           ax_reg, ay_reg;
    logic                    last_reg;
    logic [DW-1:0]           d_reg;
    logic [N1W-1:0]          n1_reg;
    logic [DW-1:0]           n2_reg;
    logic [PARAM_WIDTH-1:0]  param_reg;
    logic                    best_valid_reg;
    logic [CW-1:0]           best_x_reg, best_y_reg;
    logic [PARAM_WIDTH-1:0]  best_param_reg;
    logic                    m_valid_reg;
    logic                    out_found_reg;
    logic [CW-1:0]           out_x_reg, out_y_reg;
    logic [PARAM_WIDTH-1:0]  out_param_reg;

    logic [CW-1:0]           in_ox, in_oy, in_sx, in_sy, in_ex, in_ey;
    logic [DIR_WIDTH-1:0]    in_rx, in_ry;
    logic [SW-1:0]           in_sdx, in_sdy, in_qx, in_qy;

    nrsh_cmd_t               cmd;
    logic [NBW-1:0]          nbits;
    logic [WW-1:0]           opa, opd;
    logic [MBW-1:0]          opb;
    logic                    arith;
    logic                    u_done;
    logic [WW-1:0]           u_acc;
    logic [QW-1:0]           u_quo;

    logic                    d_neg;
    logic [DW-1:0]           d_mag;
    logic [WW-1:0]           d_wide, n1_wide, n2_wide;
    logic                    hit_ok, better, use_y;
    logic [SW-1:0]           off_delta, off_mag;
    logic [CW-1:0]           base_sel;
    logic [SW-1:0]           off_q;
    logic                    rem_nz;
    logic [CW+1:0]           off_sum;
    logic                    emit;

    assign in_ox = s_tdata[CW-1:0];
    assign in_oy = s_tdata[2*CW-1:CW];
    assign in_rx = s_tdata[2*CW +: DIR_WIDTH];
    assign in_ry = s_tdata[2*CW+DIR_WIDTH +: DIR_WIDTH];
    assign in_sx = s_tdata[2*CW+2*DIR_WIDTH +: CW];
    assign in_sy = s_tdata[3*CW+2*DIR_WIDTH +: CW];
    assign in_ex = s_tdata[4*CW+2*DIR_WIDTH +: CW];
    assign in_ey = s_tdata[5*CW+2*DIR_WIDTH +: CW];

    assign in_sdx = {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
    assign in_sdy = {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
    assign in_qx  = {in_sx[CW-1], in_sx} - {in_ox[CW-1], in_ox};
    assign in_qy  = {in_sy[CW-1], in_sy} - {in_oy[CW-1], in_oy};

    // n1 and n2 are accumulated with the sign of d folded in, so they are already normalized
    assign d_neg   = d_reg[DW-1];
    assign d_mag   = d_neg ? (~d_reg + DW'(1)) : d_reg;
    assign d_wide  = {{(WW-DW){1'b0}}, d_mag};
    assign n1_wide = {{(WW-N1W){n1_reg[N1W-1]}}, n1_reg};
    assign n2_wide = {{(WW-DW){n2_reg[DW-1]}}, n2_reg};

    assign hit_ok = (|d_reg) && !n1_reg[N1W-1] && !n2_reg[DW-1] && (n2_reg <= d_mag);
    assign better = !best_valid_reg || (param_reg < best_param_reg);

    assign use_y     = (state_reg == S_YM) || (state_reg == S_YD);
    assign off_delta = use_y ? sdy_reg : sdx_reg;
    assign off_mag   = off_delta[SW-1] ? (~off_delta + SW'(1)) : off_delta;
    assign base_sel  = use_y ? ay_reg : ax_reg;
    assign off_q     = u_quo[SW-1:0];
    assign rem_nz    = |u_acc;

    // floor of a negative offset: base - q - (remainder != 0)
    assign off_sum = {base_sel[CW-1], base_sel[CW-1], base_sel}
                   + (off_delta[SW-1] ? ~{1'b0, off_q} : {1'b0, off_q})
                   + (CW+2)'(off_delta[SW-1] & ~rem_nz);

    assign emit = (state_reg == S_DONE) && last_reg && (!m_valid_reg || m_tready);

    always_comb begin
        cmd   = '{start: 1'b0, op: OP_MUL, clr: 1'b0, neg: 1'b0};
        nbits = '0;
        opa   = '0;
        opb   = '0;
        opd   = '0;
        arith = 1'b1;
        unique case (state_reg)
            S_D0: begin
                cmd.clr = 1'b1;
                opa     = {{(WW-SW){sdy_reg[SW-1]}}, sdy_reg};
                opb     = {{(MBW-DIR_WIDTH){rx_reg[DIR_WIDTH-1]}}, rx_reg};
                nbits   = NBW'(DIR_WIDTH);
            end
            S_D1: begin
                cmd.neg = 1'b1;
                opa     = {{(WW-SW){sdx_reg[SW-1]}}, sdx_reg};
                opb     = {{(MBW-DIR_WIDTH){ry_reg[DIR_WIDTH-1]}}, ry_reg};
                nbits   = NBW'(DIR_WIDTH);
            end
            S_N1A: begin
                cmd.clr = 1'b1;
                cmd.neg = d_neg;
                opa     = {{(WW-SW){sdy_reg[SW-1]}}, sdy_reg};
                opb     = {{(MBW-SW){qx_reg[SW-1]}}, qx_reg};
                nbits   = NBW'(SW);
            end
            S_N1B: begin
                cmd.neg = ~d_neg;
                opa     = {{(WW-SW){sdx_reg[SW-1]}}, sdx_reg};
                opb     = {{(MBW-SW){qy_reg[SW-1]}}, qy_reg};
                nbits   = NBW'(SW);
            end
            S_N2A: begin
                cmd.clr = 1'b1;
                cmd.neg = d_neg;
                opa     = {{(WW-SW){qx_reg[SW-1]}}, qx_reg};
                opb     = {{(MBW-DIR_WIDTH){ry_reg[DIR_WIDTH-1]}}, ry_reg};
                nbits   = NBW'(DIR_WIDTH);
            end
            S_N2B: begin
                cmd.neg = ~d_neg;
                opa     = {{(WW-SW){qy_reg[SW-1]}}, qy_reg};
                opb     = {{(MBW-DIR_WIDTH){rx_reg[DIR_WIDTH-1]}}, rx_reg};
                nbits   = NBW'(DIR_WIDTH);
            end
            S_SAT: begin
                cmd.op = OP_DIV;
                opd    = n1_wide;
                opa    = d_wide << SAT_SHIFT;
                nbits  = NBW'(1);
            end
            S_T1: begin
                cmd.op = OP_DIV;
                opd    = n1_wide << PARAM_SHIFT;
                opa    = d_wide << T1_SHIFT;
                nbits  = NBW'(PARAM_WIDTH);
            end
            S_XM, S_YM: begin
                cmd.clr = 1'b1;
                opa     = n2_wide;
                opb     = {1'b0, off_mag};
                nbits   = NBW'(MBW);
            end
            S_XD, S_YD: begin
                cmd.op = OP_DIV;
                opd    = u_acc;
                opa    = d_wide << CW;
                nbits  = NBW'(SW);
            end
            S_IDLE, S_TEST, S_CMP, S_DONE: begin
                arith = 1'b0;
            end
        endcase
        cmd.start = arith && !pend_reg;
    end

    nrsh_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_nrsh_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .nbits   (nbits),
        .opa     (opa),
        .opb     (opb),
        .opd     (opd),
        .done    (u_done),
        .acc     (u_acc),
        .quo     (u_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_param_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.start) begin
                pend_reg <= 1'b1;
            end else if (u_done) begin
                pend_reg <= 1'b0;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        sdx_reg   <= in_sdx;
                        sdy_reg   <= in_sdy;
                        qx_reg    <= in_qx;
                        qy_reg    <= in_qy;
                        rx_reg    <= in_rx;
                        ry_reg    <= in_ry;
                        ax_reg    <= in_sx;
                        ay_reg    <= in_sy;
                        last_reg  <= s_tlast;
                        state_reg <= S_D0;
                    end
                end
                S_D0: begin
                    if (u_done) begin
                        state_reg <= S_D1;
                    end
                end
                S_D1: begin
                    if (u_done) begin
                        d_reg     <= u_acc[DW-1:0];
                        state_reg <= S_N1A;
                    end
                end
                S_N1A: begin
                    if (u_done) begin
                        state_reg <= S_N1B;
                    end
                end
                S_N1B: begin
                    if (u_done) begin
                        n1_reg    <= u_acc[N1W-1:0];
                        state_reg <= S_N2A;
                    end
                end
                S_N2A: begin
                    if (u_done) begin
                        state_reg <= S_N2B;
                    end
                end
                S_N2B: begin
                    if (u_done) begin
                        n2_reg    <= u_acc[DW-1:0];
                        state_reg <= S_TEST;
                    end
                end
                S_TEST: begin
                    state_reg <= hit_ok ? S_SAT : S_DONE;
                end
                S_SAT: begin
                    if (u_done) begin
                        if (u_quo[0]) begin
                            param_reg <= PARAM_MAX;
                            state_reg <= S_CMP;
                        end else begin
                            state_reg <= S_T1;
                        end
                    end
                end
                S_T1: begin
                    if (u_done) begin
                        param_reg <= u_quo[PARAM_WIDTH-1:0];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (better) begin
                        best_valid_reg <= 1'b1;
                        best_param_reg <= param_reg;
                        state_reg      <= S_XM;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_XM: begin
                    if (u_done) begin
                        state_reg <= S_XD;
                    end
                end
                S_XD: begin
                    if (u_done) begin
                        best_x_reg <= off_sum[CW-1:0];
                        state_reg  <= S_YM;
                    end
                end
                S_YM: begin
                    if (u_done) begin
                        state_reg <= S_YD;
                    end
                end
                S_YD: begin
                    if (u_done) begin
                        best_y_reg <= off_sum[CW-1:0];
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (emit) begin
                        out_found_reg  <= best_valid_reg;
                        out_x_reg      <= best_x_reg;
                        out_y_reg      <= best_y_reg;
                        out_param_reg  <= best_param_reg;
                        best_valid_reg <= 1'b0;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        best_param_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = OUT_W'({out_param_reg, out_y_reg, out_x_reg});

endmodule
`default_nettype wire

@@ rtl/nrsh_unit.sv @@
`default_nettype none
module nrsh_unit
    import nrsh_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CW          = COORD_WIDTH,
    localparam int WW          = (2 * CW + 22 > CW + 52) ? 2 * CW + 22 : CW + 52,
    localparam int MBW         = CW + 2,
    localparam int QW          = (CW + 1 > PARAM_WIDTH) ? CW + 1 : PARAM_WIDTH,
    localparam int MAXN        = (MBW > QW) ? MBW : QW,
    localparam int NBW         = $clog2(MAXN + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire nrsh_cmd_t           cmd,
    input  wire logic [NBW-1:0]      nbits,
    input  wire logic [WW-1:0]       opa,
    input  wire logic [MBW-1:0]      opb,
    input  wire logic [WW-1:0]       opd,
    output logic                     done,
    output logic [WW-1:0]            acc,
    output logic [QW-1:0]            quo
);

    logic [WW-1:0]  acc_reg;
    logic [WW-1:0]  ma_reg;
    logic [MBW-1:0] mb_reg;
    logic [QW-1:0]  q_reg;
    logic [NBW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic           neg_reg;
    nrsh_op_t       op_reg;

    logic           last_step;
    logic           sub;
    logic [WW-1:0]  addend;
    logic [WW-1:0]  sum;

    // multiply: signed shift-add, sign bit of the multiplier subtracts
    // divide: restoring, divisor shifts right one place per step
    assign last_step = (cnt_reg == NBW'(1));
    assign sub       = (op_reg == OP_DIV) ? 1'b1 : (neg_reg ^ last_step);
    assign addend    = sub ? ~ma_reg : ma_reg;
    assign sum       = acc_reg + addend + WW'(sub);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
            neg_reg  <= 1'b0;
        end else begin
            done_reg <= busy_reg && !cmd.start && last_step;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
                op_reg   <= cmd.op;
                neg_reg  <= cmd.neg;
                ma_reg   <= opa;
                mb_reg   <= opb;
                q_reg    <= '0;
                if (cmd.op == OP_DIV) begin
                    acc_reg <= opd;
                end else if (cmd.clr) begin
                    acc_reg <= '0;
                end
            end else if (busy_reg) begin
                unique case (op_reg)
                    OP_MUL: begin
                        if (mb_reg[0]) begin
                            acc_reg <= sum;
                        end
                        ma_reg <= ma_reg << 1;
                        mb_reg <= {mb_reg[MBW-1], mb_reg[MBW-1:1]};
                    end
                    OP_DIV: begin
                        if (!sum[WW-1]) begin
                            acc_reg <= sum;
                        end
                        q_reg  <= {q_reg[QW-2:0], ~sum[WW-1]};
                        ma_reg <= ma_reg >> 1;
                    end
                endcase
                cnt_reg <= cnt_reg - NBW'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

@@ rtl/nrsh_checker.sv @@
`default_nettype none
module nrsh_checker
    import nrsh_pkg::*;
#(
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int OUT_BITS    = 2 * COORD_WIDTH + PARAM_WIDTH,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tuser
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a run without a hit reports all-zero fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result carries nonzero fields");

    // one request at a time: busy right after a request is taken
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind nearest_ray_segment_hit_top nrsh_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_nrsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
